### rtl/core/sse_pkg.sv
// Shared types and constants for the strand sort engine.
`timescale 1ns / 1ps
package sse_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] sse_data_t;

	// Commands from the top level into the sort unit.
	typedef struct packed {
		logic ld_we;
		logic start;
	} sse_ctl_t;

	// Status from the sort unit back to the top level.
	typedef struct packed {
		logic busy;
		logic done;
	} sse_stat_t;

endpackage

### rtl/core/sse_in_if.sv
// Input channel: one list element per beat.
`timescale 1ns / 1ps
interface sse_in_if;
	import sse_pkg::*;

	logic      valid;
	logic      ready;
	sse_data_t value;
	logic      last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

### rtl/core/sse_out_if.sv
// Output channel: one sorted element per beat.
`timescale 1ns / 1ps
interface sse_out_if;
	import sse_pkg::*;

	logic      valid;
	logic      ready;
	sse_data_t sorted_value;
	logic      last_result;
	logic      overflow;

	modport source (output valid, output sorted_value, output last_result, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input last_result, input overflow,
		output ready);
endinterface

### rtl/core/strand_sort_engine_top.sv
// Top level of the strand sort engine: list loading, sort control and result output.
`timescale 1ns / 1ps
//
// Channel   Dir  Payload                                   Beat
// items     in   value (s32), last_item                    one list element
// results   out  sorted_value (s32), last_result, overflow one element, ascending order
//
// A list is loaded one element per cycle; items.ready is high only while loading, and
// the beat flagged last_item starts the sort. Each strand round splits the remaining
// elements into a strand and a remainder, then merges the strand into the sorted list,
// all on one comparator, with a wait state before each split and each merge step.
// Each result beat follows a T_OUT_WAIT state; results.ready may stall any beat and the
// payload holds. arst_n clears control state only; unwritten memory entries are never read.
module strand_sort_engine_top #(
	parameter int MAX_ITEMS = 64
) (
	input logic         clk,
	input logic         arst_n,
	sse_in_if.sink      items,
	sse_out_if.source   results
);
	import sse_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		T_LOAD,
		T_SORT,
		T_OUT_WAIT,
		T_OUT_SHOW
	} top_state_t;

	top_state_t       state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [IDX_W-1:0] k_q;

	logic             in_fire;
	logic             out_fire;
	logic             has_room;
	logic             is_last;
	logic [CNT_W-1:0] start_count;
	sse_ctl_t         ctl;
	sse_stat_t        stat;
	sse_data_t        rd_data;

	assign items.ready = state_q == T_LOAD;
	assign in_fire     = items.valid && items.ready;

	// Elements past capacity are dropped but still count toward the overflow flag;
	// the last beat ends the list whether or not it was stored.
	assign has_room    = count_q < CNT_W'(MAX_ITEMS);
	assign ctl.ld_we   = in_fire && has_room;
	assign ctl.start   = in_fire && items.last_item;
	assign start_count = has_room ? CNT_W'(count_q + CNT_W'(1)) : count_q;

	assign is_last              = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	assign results.valid        = state_q == T_OUT_SHOW;
	assign results.sorted_value = rd_data;
	assign results.last_result  = is_last;
	assign results.overflow     = ovf_q;
	assign out_fire             = results.valid && results.ready;

	sse_sorter #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_sorter (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.start_count (start_count),
		.ld_idx      (count_q[IDX_W-1:0]),
		.ld_data     (items.value),
		.rd_idx      (k_q),
		.stat        (stat),
		.rd_data     (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				T_LOAD: begin
					if (in_fire) begin
						if (has_room) begin
							count_q <= CNT_W'(count_q + CNT_W'(1));
						end else begin
							ovf_q <= 1'b1;
						end
						if (items.last_item) begin
							state_q <= T_SORT;
						end
					end
				end
				T_SORT: begin
					// The sort unit flips its result bank as it finishes, so the
					// first read is issued in the following state, T_OUT_WAIT.
					if (stat.done) begin
						k_q     <= '0;
						state_q <= T_OUT_WAIT;
					end
				end
				T_OUT_WAIT: begin
					state_q <= T_OUT_SHOW;
				end
				T_OUT_SHOW: begin
					if (out_fire) begin
						if (is_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= T_LOAD;
						end else begin
							k_q     <= IDX_W'(k_q + IDX_W'(1));
							state_q <= T_OUT_WAIT;
						end
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

endmodule

### rtl/core/sse_sorter.sv
// Strand sort sequencer with its three list memories and one shared comparator.
`timescale 1ns / 1ps
module sse_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sse_pkg::sse_ctl_t                  ctl,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]     start_count,
	input  logic [$clog2(MAX_ITEMS)-1:0]       ld_idx,
	input  sse_pkg::sse_data_t                 ld_data,
	input  logic [$clog2(MAX_ITEMS)-1:0]       rd_idx,
	output sse_pkg::sse_stat_t                 stat,
	output sse_pkg::sse_data_t                 rd_data
);
	import sse_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_X_HEAD,
		S_X_FIRST,
		S_X_WAIT,
		S_X_STEP,
		S_M_WAIT,
		S_M_STEP
	} sort_state_t;

	sort_state_t state_q;

	logic [CNT_W-1:0] remain_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] keep_q;
	logic [CNT_W-1:0] slen_q;
	logic [CNT_W-1:0] sl_q;
	logic [CNT_W-1:0] a_q;
	logic [CNT_W-1:0] s_q;
	logic [CNT_W-1:0] wr_q;
	logic             bank_q;
	logic             done_q;
	sse_data_t        tail_q;

	sse_data_t unsorted_mem [MAX_ITEMS];
	sse_data_t strand_mem [MAX_ITEMS];
	sse_data_t sorted_mem [2][MAX_ITEMS];

	sse_data_t u_rd_q;
	sse_data_t s_rd_q;
	sse_data_t o_rd_q;

	sse_data_t        cmp_a;
	sse_data_t        cmp_b;
	logic             cmp_lt;
	logic             x_take;
	logic             m_take_old;
	logic [CNT_W-1:0] merge_total;
	logic [CNT_W-1:0] wr_next;
	logic [CNT_W-1:0] i_next;

	logic             u_we;
	logic [IDX_W-1:0] u_waddr;
	sse_data_t        u_wdata;
	logic             s_we;
	logic [IDX_W-1:0] s_waddr;
	logic [IDX_W-1:0] o_raddr;

	// The single signed comparator, shared by strand extraction and merging.
	always_comb begin
		if (state_q == S_M_STEP) begin
			cmp_a = o_rd_q;
			cmp_b = s_rd_q;
		end else begin
			cmp_a = u_rd_q;
			cmp_b = tail_q;
		end
	end

	assign cmp_lt      = cmp_a < cmp_b;
	assign x_take      = !cmp_lt;
	assign m_take_old  = (a_q < sl_q) && ((s_q >= slen_q) || cmp_lt);
	assign merge_total = CNT_W'(sl_q + slen_q);
	assign wr_next     = CNT_W'(wr_q + CNT_W'(1));
	assign i_next      = CNT_W'(i_q + CNT_W'(1));

	assign u_we    = ctl.ld_we || ((state_q == S_X_STEP) && !x_take);
	assign u_waddr = ctl.ld_we ? ld_idx : keep_q[IDX_W-1:0];
	assign u_wdata = ctl.ld_we ? ld_data : u_rd_q;
	assign s_we    = (state_q == S_X_FIRST) || ((state_q == S_X_STEP) && x_take);
	assign s_waddr = (state_q == S_X_FIRST) ? '0 : slen_q[IDX_W-1:0];
	assign o_raddr = (state_q == S_IDLE) ? rd_idx : a_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (u_we) begin
			unsorted_mem[u_waddr] <= u_wdata;
		end
		u_rd_q <= unsorted_mem[i_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			strand_mem[s_waddr] <= u_rd_q;
		end
		s_rd_q <= strand_mem[s_q[IDX_W-1:0]];
	end

	// The merge writes the other bank while reading the current one.
	always_ff @(posedge clk) begin
		if (state_q == S_M_STEP) begin
			sorted_mem[!bank_q][wr_q[IDX_W-1:0]] <= m_take_old ? o_rd_q : s_rd_q;
		end
		o_rd_q <= sorted_mem[bank_q][o_raddr];
	end

	assign rd_data   = o_rd_q;
	assign stat.busy = state_q != S_IDLE;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			remain_q <= '0;
			i_q      <= '0;
			keep_q   <= '0;
			slen_q   <= '0;
			sl_q     <= '0;
			a_q      <= '0;
			s_q      <= '0;
			wr_q     <= '0;
			bank_q   <= 1'b0;
			done_q   <= 1'b0;
			tail_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						remain_q <= start_count;
						sl_q     <= '0;
						i_q      <= '0;
						state_q  <= S_X_HEAD;
					end
				end
				S_X_HEAD: begin
					state_q <= S_X_FIRST;
				end
				S_X_FIRST: begin
					tail_q <= u_rd_q;
					slen_q <= CNT_W'(1);
					keep_q <= '0;
					if (remain_q == CNT_W'(1)) begin
						remain_q <= '0;
						a_q      <= '0;
						s_q      <= '0;
						wr_q     <= '0;
						state_q  <= S_M_WAIT;
					end else begin
						i_q     <= CNT_W'(1);
						state_q <= S_X_WAIT;
					end
				end
				S_X_WAIT: begin
					state_q <= S_X_STEP;
				end
				S_X_STEP: begin
					if (x_take) begin
						tail_q <= u_rd_q;
						slen_q <= CNT_W'(slen_q + CNT_W'(1));
					end else begin
						keep_q <= CNT_W'(keep_q + CNT_W'(1));
					end
					i_q <= i_next;
					if (i_next == remain_q) begin
						remain_q <= x_take ? keep_q : CNT_W'(keep_q + CNT_W'(1));
						a_q      <= '0;
						s_q      <= '0;
						wr_q     <= '0;
						state_q  <= S_M_WAIT;
					end else begin
						state_q <= S_X_WAIT;
					end
				end
				S_M_WAIT: begin
					state_q <= S_M_STEP;
				end
				S_M_STEP: begin
					if (m_take_old) begin
						a_q <= CNT_W'(a_q + CNT_W'(1));
					end else begin
						s_q <= CNT_W'(s_q + CNT_W'(1));
					end
					wr_q <= wr_next;
					if (wr_next == merge_total) begin
						sl_q   <= wr_next;
						bank_q <= !bank_q;
						if (remain_q == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q     <= '0;
							state_q <= S_X_HEAD;
						end
					end else begin
						state_q <= S_M_WAIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A new list starts only while the unit is idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> (state_q == S_IDLE))
		else $error("sort start while busy");

	// Every scanned element went either to the strand or back to the remainder.
	a_split_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_X_STEP) |-> (CNT_W'(keep_q + slen_q) == i_q))
		else $error("strand split lost an element");

	// Every merge output consumed exactly one element from one of the two lists.
	a_merge_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M_STEP) |-> (CNT_W'(a_q + s_q) == wr_q))
		else $error("merge pointers out of step");

	// The sorted list never grows past capacity.
	a_sorted_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sl_q <= CNT_W'(MAX_ITEMS))
		else $error("sorted list exceeds capacity");

endmodule
